>>> src/lorenz_pkg.sv
// Shared types, constants and the microcode table of the Lorenz Euler step block.
package lorenz_pkg;

    // Fixed-point format: signed Q8.24
    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 2 * DATA_W + 1;
    localparam int SQ_W      = 2 * DATA_W;
    localparam int DIST_W    = DATA_W - 1;

    // Reset x coordinate: 0.1 rounded to nearest
    localparam logic signed [DATA_W-1:0] POINT_X_RESET =
        DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // Half an LSB of the product, for round to nearest
    localparam logic signed [WIDE_W-1:0] ROUND_HALF = 65'sd1 << (FRAC_BITS - 1);

    // Microcode length and square root length
    localparam int NUM_UOPS   = 20;
    localparam int UOP_W      = $clog2(NUM_UOPS);
    localparam int ROOT_STEPS = DATA_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SQ
    } t_op;

    // Operand sources and writeback destinations
    typedef enum logic [3:0] {
        SEL_H,
        SEL_A,
        SEL_B,
        SEL_C,
        SEL_X0,
        SEL_Y0,
        SEL_Z0,
        SEL_X1,
        SEL_Y1,
        SEL_Z1,
        SEL_T0,
        SEL_T1,
        SEL_ACC
    } t_sel;

    // One microcode word
    typedef struct packed {
        t_op  op;
        t_sel src_a;
        t_sel src_b;
        t_sel dst;
    } t_uop;

    // Request to the shared arithmetic unit
    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_alu_req;

    // Saturate an exact wide value to 32 bits signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 65'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -65'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Microcode: Euler update followed by the six squares
    function automatic t_uop uop_at(input logic [UOP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:    u = '{OP_SUB, SEL_Y0, SEL_X0, SEL_T0};  // y0 - x0
            5'd1:    u = '{OP_MUL, SEL_H,  SEL_A,  SEL_T1};  // h * sigma
            5'd2:    u = '{OP_MUL, SEL_T1, SEL_T0, SEL_T0};
            5'd3:    u = '{OP_ADD, SEL_X0, SEL_T0, SEL_X1};
            5'd4:    u = '{OP_SUB, SEL_B,  SEL_Z0, SEL_T0};  // rho - z0
            5'd5:    u = '{OP_MUL, SEL_X0, SEL_T0, SEL_T0};
            5'd6:    u = '{OP_SUB, SEL_T0, SEL_Y0, SEL_T0};
            5'd7:    u = '{OP_MUL, SEL_H,  SEL_T0, SEL_T0};
            5'd8:    u = '{OP_ADD, SEL_Y0, SEL_T0, SEL_Y1};
            5'd9:    u = '{OP_MUL, SEL_X0, SEL_Y0, SEL_T0};  // x0 * y0
            5'd10:   u = '{OP_MUL, SEL_C,  SEL_Z0, SEL_T1};  // beta * z0
            5'd11:   u = '{OP_SUB, SEL_T0, SEL_T1, SEL_T0};
            5'd12:   u = '{OP_MUL, SEL_H,  SEL_T0, SEL_T0};
            5'd13:   u = '{OP_ADD, SEL_Z0, SEL_T0, SEL_Z1};
            5'd14:   u = '{OP_SQ,  SEL_X0, SEL_X0, SEL_ACC};
            5'd15:   u = '{OP_SQ,  SEL_Y0, SEL_Y0, SEL_ACC};
            5'd16:   u = '{OP_SQ,  SEL_Z0, SEL_Z0, SEL_ACC};
            5'd17:   u = '{OP_SQ,  SEL_X1, SEL_X1, SEL_ACC};
            5'd18:   u = '{OP_SQ,  SEL_Y1, SEL_Y1, SEL_ACC};
            5'd19:   u = '{OP_SQ,  SEL_Z1, SEL_Z1, SEL_ACC};
            default: u = '{OP_ADD, SEL_H,  SEL_H,  SEL_T0};
        endcase
        return u;
    endfunction

endpackage

>>> src/lorenz_in_if.sv
// Input channel: step size and Lorenz coefficients per request.
interface lorenz_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] step_size;
    logic signed [31:0] sigma;
    logic signed [31:0] rho;
    logic signed [31:0] beta;

    modport source (output valid, step_size, sigma, rho, beta, input ready);
    modport sink   (input valid, step_size, sigma, rho, beta, output ready);
endinterface

>>> src/lorenz_out_if.sv
// Output channel: new point and joint distance per request.
interface lorenz_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_next;
    logic signed [31:0] y_next;
    logic signed [31:0] z_next;
    logic        [30:0] joint_distance;

    modport source (output valid, x_next, y_next, z_next, joint_distance, input ready);
    modport sink   (input valid, x_next, y_next, z_next, joint_distance, output ready);
endinterface

>>> src/lorenz_alu.sv
// Shared two-stage arithmetic unit: add, subtract, rounded multiply, square.
module lorenz_alu (
    input  logic                                    i_clk,
    input  lorenz_pkg::t_alu_req                    i_req,
    output logic signed [lorenz_pkg::DATA_W-1:0]    o_result,
    output logic        [lorenz_pkg::SQ_W-1:0]      o_square
);
    import lorenz_pkg::*;

    logic signed [WIDE_W-1:0] r_wide;
    t_op                      r_op;
    logic signed [SQ_W-1:0]   prod;
    logic signed [WIDE_W-1:0] scaled;

    // Exact product of the operands
    assign prod = SQ_W'(i_req.a) * SQ_W'(i_req.b);

    // Stage one: exact result, held for the next cycle
    always_ff @(posedge i_clk) begin
        r_op <= i_req.op;
        case (i_req.op)
            OP_ADD:  r_wide <= WIDE_W'(i_req.a) + WIDE_W'(i_req.b);
            OP_SUB:  r_wide <= WIDE_W'(i_req.a) - WIDE_W'(i_req.b);
            OP_MUL:  r_wide <= WIDE_W'(prod);
            OP_SQ:   r_wide <= WIDE_W'(prod);
            default: r_wide <= '0;
        endcase
    end

    // Stage two: round a multiply to nearest, then saturate every result
    always_comb begin
        if (r_op == OP_MUL) begin
            scaled = (r_wide + ROUND_HALF) >>> FRAC_BITS;
        end else begin
            scaled = r_wide;
        end
    end

    assign o_result = sat32(scaled);
    assign o_square = r_wide[SQ_W-1:0];

endmodule

>>> src/lorenz_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module lorenz_isqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lorenz_pkg::SQ_W-1:0]        i_value,
    output logic                               o_done,
    output logic [lorenz_pkg::DATA_W-1:0]      o_root
);
    import lorenz_pkg::*;

    localparam int REM_W = DATA_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic                  r_busy;
    logic                  r_done;
    logic [ROOT_CNT_W-1:0] r_count;
    logic [SQ_W-1:0]       r_val;
    logic [REM_W-1:0]      r_rem;
    logic [DATA_W-1:0]     r_root;

    logic [TRY_W-1:0]      shifted;
    logic [TRY_W-1:0]      trial;
    logic [TRY_W-1:0]      diff;
    logic                  fits;

    // Bring down the next two bits and try the next root bit
    assign shifted = {r_rem, r_val[SQ_W-1 -: 2]};
    assign trial   = TRY_W'({r_root, 2'b01});
    assign diff    = shifted - trial;
    assign fits    = (shifted >= trial);

    // Control: step once for each root bit, then flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring digit recurrence
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQ_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= diff[REM_W-1:0];
                r_root <= {r_root[DATA_W-2:0], 1'b1};
            end else begin
                r_rem  <= shifted[REM_W-1:0];
                r_root <= {r_root[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> src/lorenz_euler_step.sv
// Top level of the Lorenz Euler step block: sequencer, operand registers, output stage.
//
// Each accepted request takes one forward Euler step of the Lorenz system from
// the stored point (reset to 0.1, 0, 0) and returns the new point and the floor
// square root of the summed squares of the old and new points, the point in
// signed Q8.24 and the distance in unsigned Q7.24, both with saturation. With the
// output free, a request passes the accepting state, 20 micro-operations, each
// an issue and a write back, on the single shared multiplier/adder, the
// bit-serial square root until it flags done, and a last state that hands the
// result to the output register. The input is not ready while a request is in
// work; a finished result sits in the output register, so the next request may
// be accepted before it is taken. A result still waiting there holds the next
// one in its last state, and the input stays not ready until it is taken.
module lorenz_euler_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lorenz_in_if.sink    i_in,
    lorenz_out_if.source o_out
);
    import lorenz_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WB    = 5'b00100,
        ST_ROOT  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [UOP_W-1:0]         r_step;

    // Request operands and the stored point
    logic signed [DATA_W-1:0] r_h, r_a, r_b, r_c;
    logic signed [DATA_W-1:0] r_x0, r_y0, r_z0;
    logic signed [DATA_W-1:0] r_x1, r_y1, r_z1;
    logic signed [DATA_W-1:0] r_t0, r_t1;
    logic [SQ_W-1:0]          r_acc;

    // Output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_x, r_out_y, r_out_z;
    logic [DIST_W-1:0]        r_out_dist;

    t_uop                     uop;
    t_alu_req                 alu_req;
    logic signed [DATA_W-1:0] alu_result;
    logic [SQ_W-1:0]          alu_square;
    logic [SQ_W:0]            acc_sum;
    logic [SQ_W-1:0]          n_acc;
    logic                     root_start;
    logic                     root_done;
    logic [DATA_W-1:0]        root;
    logic                     last_uop;
    logic                     out_free;

    assign uop      = uop_at(r_step);
    assign last_uop = (r_step == UOP_W'(NUM_UOPS - 1));
    assign out_free = !r_out_valid || o_out.ready;

    // Select the operation and both operands
    always_comb begin
        alu_req.op = uop.op;
        case (uop.src_a)
            SEL_H:   alu_req.a = r_h;
            SEL_A:   alu_req.a = r_a;
            SEL_B:   alu_req.a = r_b;
            SEL_C:   alu_req.a = r_c;
            SEL_X0:  alu_req.a = r_x0;
            SEL_Y0:  alu_req.a = r_y0;
            SEL_Z0:  alu_req.a = r_z0;
            SEL_X1:  alu_req.a = r_x1;
            SEL_Y1:  alu_req.a = r_y1;
            SEL_Z1:  alu_req.a = r_z1;
            SEL_T0:  alu_req.a = r_t0;
            SEL_T1:  alu_req.a = r_t1;
            default: alu_req.a = '0;
        endcase
        case (uop.src_b)
            SEL_H:   alu_req.b = r_h;
            SEL_A:   alu_req.b = r_a;
            SEL_B:   alu_req.b = r_b;
            SEL_C:   alu_req.b = r_c;
            SEL_X0:  alu_req.b = r_x0;
            SEL_Y0:  alu_req.b = r_y0;
            SEL_Z0:  alu_req.b = r_z0;
            SEL_X1:  alu_req.b = r_x1;
            SEL_Y1:  alu_req.b = r_y1;
            SEL_Z1:  alu_req.b = r_z1;
            SEL_T0:  alu_req.b = r_t0;
            SEL_T1:  alu_req.b = r_t1;
            default: alu_req.b = '0;
        endcase
    end

    lorenz_alu u_alu (
        .i_clk    (i_clk),
        .i_req    (alu_req),
        .o_result (alu_result),
        .o_square (alu_square)
    );

    // Accumulate squares, saturating at all ones
    assign acc_sum = {1'b0, r_acc} + {1'b0, alu_square};
    assign n_acc   = acc_sum[SQ_W] ? '1 : acc_sum[SQ_W-1:0];

    assign root_start = (r_state == ST_WB) && last_uop;

    lorenz_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (n_acc),
        .o_done  (root_done),
        .o_root  (root)
    );

    // Sequencer and stored point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_x0    <= POINT_X_RESET;
            r_y0    <= '0;
            r_z0    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_step  <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (last_uop) begin
                        r_state <= ST_ROOT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ROOT: begin
                    if (root_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Advance the point once the result has a place to go
                    if (out_free) begin
                        r_x0    <= r_x1;
                        r_y0    <= r_y1;
                        r_z0    <= r_z1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture request operands and write back unit results
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_h   <= i_in.step_size;
            r_a   <= i_in.sigma;
            r_b   <= i_in.rho;
            r_c   <= i_in.beta;
            r_acc <= '0;
        end
        if (r_state == ST_WB) begin
            case (uop.dst)
                SEL_X1:  r_x1  <= alu_result;
                SEL_Y1:  r_y1  <= alu_result;
                SEL_Z1:  r_z1  <= alu_result;
                SEL_T0:  r_t0  <= alu_result;
                SEL_T1:  r_t1  <= alu_result;
                SEL_ACC: r_acc <= n_acc;
                default: ;
            endcase
        end
    end

    // Output register: load on completion, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_x    <= r_x1;
            r_out_y    <= r_y1;
            r_out_z    <= r_z1;
            r_out_dist <= root[DATA_W-1] ? '1 : root[DIST_W-1:0];
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.x_next         = r_out_x;
    assign o_out.y_next         = r_out_y;
    assign o_out.z_next         = r_out_z;
    assign o_out.joint_distance = r_out_dist;

endmodule

>>> dv/tb_lorenz_euler_step.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Lorenz Euler step block.
module tb_lorenz_euler_step;

    localparam int FRAC = lorenz_pkg::FRAC_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int END_SETTLE = 100;

    localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE  = 32'sh0100_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0080_0000;
    localparam logic signed [31:0] Q_LSB  = 32'sh0000_0001;
    localparam logic signed [31:0] Q_NEG1 = 32'shffff_ffff;

    typedef struct {
        logic signed [31:0] h;
        logic signed [31:0] sigma;
        logic signed [31:0] rho;
        logic signed [31:0] beta;
    } t_step_req;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [30:0] distance;
    } t_step_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lorenz_in_if  req_if ();
    lorenz_out_if res_if ();

    lorenz_euler_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Tracked point of the attractor and the results it still owes
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
    t_step_res pending_points[$];
    t_step_res want;

    int mismatch_count = 0;
    int steps_sent     = 0;
    int steps_checked  = 0;
    int coord_sat_seen = 0;
    int dist_sat_seen  = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_off_req   = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Saturate an exact wide value to signed 32 bits
    function automatic logic signed [31:0] clamp_s32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return Q_MAX;
        end
        if (v < -66'sd2147483648) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Fixed-point product: round to nearest, ties up, then saturate
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic signed [65:0] p;
        wa = a;
        wb = b;
        p = wa * wb + (66'sd1 <<< (FRAC - 1));
        return clamp_s32(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        wa = a;
        wb = b;
        return clamp_s32(wa + wb);
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        wa = a;
        wb = b;
        return clamp_s32(wa - wb);
    endfunction

    // Square a coordinate exactly
    function automatic logic [63:0] q_square(input logic signed [31:0] a);
        logic signed [65:0] wa;
        logic signed [65:0] sq;
        wa = a;
        sq = wa * wa;
        return sq[63:0];
    endfunction

    // Floor square root, one result bit at a time from the top
    function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= v) begin
                root = cand;
            end
        end
        return root;
    endfunction

    // Advance the tracked point by one Euler step and return the new point
    function automatic t_step_res advance_point(input t_step_req r);
        t_step_res res;
        logic signed [31:0] t;
        logic signed [31:0] u;
        logic [66:0] acc;
        logic [63:0] root;

        t = q_mul(q_mul(r.h, r.sigma), q_sub(pt_y, pt_x));
        res.x = q_add(pt_x, t);

        t = q_sub(q_mul(pt_x, q_sub(r.rho, pt_z)), pt_y);
        res.y = q_add(pt_y, q_mul(r.h, t));

        t = q_mul(pt_x, pt_y);
        u = q_mul(r.beta, pt_z);
        res.z = q_add(pt_z, q_mul(r.h, q_sub(t, u)));

        // Squares are non-negative, so clamping once at the end is enough
        acc = {3'b0, q_square(pt_x)} + {3'b0, q_square(pt_y)} + {3'b0, q_square(pt_z)}
            + {3'b0, q_square(res.x)} + {3'b0, q_square(res.y)} + {3'b0, q_square(res.z)};
        if (acc > {3'b0, {64{1'b1}}}) begin
            acc = {3'b0, {64{1'b1}}};
        end
        root = floor_sqrt64(acc[63:0]);
        res.distance = (root > 64'h7fff_ffff) ? 31'h7fff_ffff : root[30:0];

        pt_x = res.x;
        pt_y = res.y;
        pt_z = res.z;
        return res;
    endfunction

    // Send one request, idling first at random, and record its expected result
    task automatic send_step(input t_step_req r);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.step_size <= r.h;
        req_if.sigma     <= r.sigma;
        req_if.rho       <= r.rho;
        req_if.beta      <= r.beta;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_points.push_back(advance_point(r));
        steps_sent++;
    endtask

    // Drop valid in the step of the last acceptance
    task automatic stop_requests();
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_step_req make_req(input logic signed [31:0] h,
                                           input logic signed [31:0] sigma,
                                           input logic signed [31:0] rho,
                                           input logic signed [31:0] beta);
        t_step_req r;
        r.h = h;
        r.sigma = sigma;
        r.rho = rho;
        r.beta = beta;
        return r;
    endfunction

    // Coefficients near the classic chaotic setting, small positive step
    function automatic t_step_req orbit_req();
        return make_req(32'($urandom_range(16777, 167772)),
                        32'($urandom_range(8 << 24, 12 << 24)),
                        32'($urandom_range(20 << 24, 32 << 24)),
                        32'($urandom_range(2 << 24, 3 << 24)));
    endfunction

    // Full-range value, biased toward the format's corners
    function automatic logic signed [31:0] wild_value();
        case ($urandom_range(0, 11))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_NEG1;
            4:       return Q_ONE;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic t_step_req wild_req();
        return make_req(wild_value(), wild_value(), wild_value(), wild_value());
    endfunction

    // Disturb an orbit request without throwing the point off the attractor
    function automatic t_step_req noisy_req(input t_step_req r);
        t_step_req n;
        n = r;
        case ($urandom_range(0, 2))
            0: begin
                // zero step keeps the point; coefficients roam the full range
                n.h = '0;
                n.sigma = 32'($urandom);
                n.rho = 32'($urandom);
                n.beta = 32'($urandom);
            end
            1: n.h = -r.h;
            default: begin
                case ($urandom_range(0, 2))
                    0:       n.sigma = 32'($urandom);
                    1:       n.rho = 32'($urandom);
                    default: n.beta = 32'($urandom);
                endcase
            end
        endcase
        return n;
    endfunction

    // Compare one result field and report a difference
    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %h, got %h", $time, what, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Check each accepted result against the oldest pending point
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: result with none pending, got x %h y %h z %h d %h", $time,
                         res_if.x_next, res_if.y_next, res_if.z_next, res_if.joint_distance);
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                check_field("x_next", want.x, res_if.x_next);
                check_field("y_next", want.y, res_if.y_next);
                check_field("z_next", want.z, res_if.z_next);
                check_field("joint_distance", {1'b0, want.distance},
                            {1'b0, res_if.joint_distance});
                steps_checked++;
                if (want.x inside {Q_MAX, Q_MIN} || want.y inside {Q_MAX, Q_MIN}
                        || want.z inside {Q_MAX, Q_MIN}) begin
                    coord_sat_seen++;
                end
                if (want.distance == 31'h7fff_ffff) begin
                    dist_sat_seen++;
                end
            end
        end
    end

    // Result-side ready: random stall bursts and a long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                stall_left = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("lorenz_euler_step: mismatch");
            $finish;
        end
    end

    // Field extremes and rounding ties from the reset point, then a few real steps
    task automatic test_reset_and_extremes();
        idle_pct = 20;
        stall_pct = 20;
        // zero step holds the point whatever the coefficients
        send_step(make_req('0, Q_MAX, Q_MAX, Q_MAX));
        send_step(make_req('0, Q_MIN, Q_MIN, Q_MIN));
        send_step(make_req('0, Q_NEG1, Q_NEG1, Q_NEG1));
        // extreme steps with zero coefficients also hold the reset point
        send_step(make_req(Q_MAX, '0, '0, '0));
        send_step(make_req(Q_MIN, '0, '0, '0));
        send_step(make_req(Q_NEG1, '0, '0, '0));
        // h*sigma lands exactly on half an LSB, both signs
        send_step(make_req(Q_HALF, Q_LSB, '0, '0));
        send_step(make_req(Q_HALF, -Q_LSB, '0, '0));
        // classic coefficients: h 0.01, sigma 10, rho 28, beta 8/3
        repeat (3) send_step(make_req(32'sd167772, 32'sd167772160, 32'sd469762048,
                                      32'sd44739243));
        stop_requests();
        wait_drained();
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_off_req = 400;
        repeat (8) send_step(orbit_req());
        stop_requests();
        wait_drained();
    endtask

    // Long trajectory on the attractor with occasional disturbances
    task automatic test_orbit();
        t_step_req r;
        for (int i = 0; i < 470; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 8;
                    default: idle_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    default: stall_pct = 30;
                endcase
            end
            r = orbit_req();
            if ($urandom_range(1, 100) <= 15) begin
                r = noisy_req(r);
            end
            send_step(r);
        end
        stop_requests();
        wait_drained();
    endtask

    // Drive intermediates and the distance into saturation
    task automatic test_saturation_corners();
        idle_pct = 15;
        stall_pct = 15;
        send_step(make_req(Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        send_step(make_req(Q_MAX, Q_MIN, Q_MIN, Q_MAX));
        send_step(make_req(Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_step(make_req(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_step(make_req(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_step(make_req(Q_ONE, Q_ONE, Q_MIN, Q_ONE));
        stop_requests();
        wait_drained();
    endtask

    // Full-range random requests
    task automatic test_wild_values();
        idle_pct = 20;
        stall_pct = 20;
        repeat (150) send_step(wild_req());
        stop_requests();
        wait_drained();
    endtask

    // Back-to-back stream with both sides always ready
    task automatic test_steady_stream();
        idle_pct = 0;
        stall_pct = 0;
        repeat (100) begin
            if ($urandom_range(0, 1) == 0) begin
                send_step(wild_req());
            end else begin
                send_step(orbit_req());
            end
        end
        stop_requests();
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.step_size = '0;
        req_if.sigma = '0;
        req_if.rho = '0;
        req_if.beta = '0;
        pt_x = 32'(((64'd1 << FRAC) + 64'd5) / 64'd10);
        pt_y = '0;
        pt_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_extremes();
        test_backpressure();
        test_orbit();
        test_saturation_corners();
        test_wild_values();
        test_steady_stream();

        repeat (END_SETTLE) @(posedge i_clk);
        mismatch_count += pending_points.size();
        $display("Sent %0d Euler steps (extremes, hold-off, orbit, corners, wild, stream)",
                 steps_sent);
        $display("Checked %0d points: %0d with a clamped coordinate, %0d clamped distances",
                 steps_checked, coord_sat_seen, dist_sat_seen);
        if (mismatch_count == 0) begin
            $display("lorenz_euler_step: match");
        end else begin
            $display("lorenz_euler_step: mismatch");
        end
        $finish;
    end

endmodule
